// ===== rtl/sliding_window_median_unit_assert.svh =====
// Assertion macros used by the controller of the sliding window median unit.
// Needs a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef SLIDING_WINDOW_MEDIAN_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SWM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swm assertion failed");

// Next-cycle implication, disabled while in reset.
`define SWM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swm assertion failed");

`endif

// ===== rtl/swm_pkg.sv =====
// Package for the sliding window median unit: sizes, controller states and
// the command struct from controller to datapath. No dependencies.
package swm_pkg;

	localparam int SAMPLE_WIDTH = 32;
	localparam int MAX_WINDOW   = 64;
	localparam int WIN_W        = 7;
	localparam int IDX_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(3);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_STEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             capture;
		logic [IDX_W-1:0] ring_raddr;
		logic             ring_we;
		logic [IDX_W-1:0] ring_waddr;
		logic [IDX_W-1:0] sort_raddr;
		logic             sort_we;
		logic [IDX_W-1:0] sort_waddr;
		logic             prime;
		logic             step;
		logic             last;
		logic             full;
		logic             med_hit;
		logic             out_load;
	} cmd_t;

endpackage

// ===== rtl/sliding_window_median_unit.sv =====
// Top level of the sliding window median unit: ties the controller to the
// datapath. Depends on swm_pkg, swm_controller and swm_datapath.
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall   sample [31:0]
//  out       output     out_valid / out_stall median [31:0]
//  config    input      window_size_we       window_size [6:0]
//
// After acceptance an item goes through the prime state and merge steps 0 to
// L, where L is the index of the last step of the sorted merge pass: W - 1 once
// the window is full, the fill count while it fills. The pass reads and writes
// one entry per cycle of the sorted RAM and no new word is taken until it ends.
// Reset clears the counters and handshake state at once; the RAMs are not
// cleared, since only written entries are ever used.
// A stalled result waits in the output register while the next word is
// already taken; the pass then holds its result until that register frees.

module sliding_window_median_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [swm_pkg::SAMPLE_WIDTH-1:0] sample,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [swm_pkg::SAMPLE_WIDTH-1:0] median,
	input  logic                             window_size_we,
	input  logic [swm_pkg::WIN_W-1:0]        window_size
);

	// Commands from sequencer to datapath.
	swm_pkg::cmd_t cmd;

	// Sequence each word: capture, prime the read pipeline, merge, deliver.
	swm_controller u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.window_size_we (window_size_we),
		.window_size    (window_size),
		.cmd            (cmd)
	);

	// Drop the oldest sample and insert the new one in a single sorted pass;
	// pick the median off the write stream as it goes by.
	swm_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (sample),
		.median (median)
	);

endmodule

// ===== rtl/swm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module swm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/swm_datapath.sv =====
// Datapath of the sliding window median unit: arrival ring, sorted store and
// the merge pass registers. Depends on swm_pkg and swm_ram.
module swm_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  swm_pkg::cmd_t                    cmd,
	input  logic [swm_pkg::SAMPLE_WIDTH-1:0] sample,
	output logic [swm_pkg::SAMPLE_WIDTH-1:0] median
);

	logic [swm_pkg::SAMPLE_WIDTH-1:0] sample_q;
	logic [swm_pkg::SAMPLE_WIDTH-1:0] old_q;
	logic [swm_pkg::SAMPLE_WIDTH-1:0] cur_q;
	logic [swm_pkg::SAMPLE_WIDTH-1:0] carry_q;
	logic [swm_pkg::SAMPLE_WIDTH-1:0] med_pass_q;
	logic [swm_pkg::SAMPLE_WIDTH-1:0] median_q;
	logic                             removed_q;

	logic [swm_pkg::SAMPLE_WIDTH-1:0] ring_rdata;
	logic [swm_pkg::SAMPLE_WIDTH-1:0] sort_rdata;
	logic [swm_pkg::SAMPLE_WIDTH-1:0] sort_wdata;
	logic [swm_pkg::SAMPLE_WIDTH-1:0] b_val;
	logic                             hit_old;
	logic                             take_carry;

	swm_ram #(
		.WIDTH (swm_pkg::SAMPLE_WIDTH),
		.DEPTH (swm_pkg::MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (cmd.ring_we),
		.waddr (cmd.ring_waddr),
		.wdata (sample_q),
		.raddr (cmd.ring_raddr),
		.rdata (ring_rdata)
	);

	swm_ram #(
		.WIDTH (swm_pkg::SAMPLE_WIDTH),
		.DEPTH (swm_pkg::MAX_WINDOW)
	) u_sorted (
		.clk   (clk),
		.we    (cmd.sort_we),
		.waddr (cmd.sort_waddr),
		.wdata (sort_wdata),
		.raddr (cmd.sort_raddr),
		.rdata (sort_rdata)
	);

	// Element of the old list with the departing sample dropped once.
	always_comb begin
		hit_old    = cmd.full && (cur_q == old_q);
		b_val      = (cmd.full && (removed_q || hit_old)) ? sort_rdata : cur_q;
		take_carry = cmd.last || (b_val > carry_q);
		sort_wdata = take_carry ? carry_q : b_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			removed_q <= 1'b0;
		end else if (cmd.prime) begin
			removed_q <= 1'b0;
		end else if (cmd.step && hit_old) begin
			removed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
		end
		if (cmd.prime) begin
			old_q   <= ring_rdata;
			cur_q   <= sort_rdata;
			carry_q <= sample_q;
		end else if (cmd.step) begin
			cur_q <= sort_rdata;
			if (!cmd.last && take_carry) begin
				carry_q <= b_val;
			end
		end
		if (cmd.step && cmd.med_hit) begin
			med_pass_q <= sort_wdata;
		end
		if (cmd.out_load) begin
			median_q <= med_pass_q;
		end
	end

	assign median = median_q;

endmodule

// ===== rtl/swm_controller.sv =====
// Controller of the sliding window median unit: handshakes, window register,
// fill and ring counters and the merge pass sequencer. Depends on swm_pkg
// and the assertion macro header.
`include "sliding_window_median_unit_assert.svh"

module swm_controller (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	output logic                      out_valid,
	input  logic                      out_stall,
	input  logic                      window_size_we,
	input  logic [swm_pkg::WIN_W-1:0] window_size,
	output swm_pkg::cmd_t             cmd
);

	swm_pkg::state_t state_q, state_d;

	logic [swm_pkg::WIN_W-1:0] win_q;
	logic [swm_pkg::CNT_W-1:0] fill_q;
	logic [swm_pkg::IDX_W-1:0] ptr_q;
	logic [swm_pkg::IDX_W-1:0] slot_q;
	logic [swm_pkg::IDX_W-1:0] len_q;
	logic [swm_pkg::IDX_W-1:0] med_idx_q;
	logic [swm_pkg::IDX_W-1:0] i_q;
	logic                      full_q;
	logic                      res_q;
	logic                      out_valid_q;

	logic [swm_pkg::CNT_W-1:0] w_eff;
	logic                      full_now;
	logic [swm_pkg::IDX_W-1:0] slot_now;
	logic [swm_pkg::CNT_W-1:0] slot_inc;
	logic                      accept;
	logic                      last_step;
	logic                      out_free;

	always_comb begin
		if (win_q == '0) begin
			w_eff = swm_pkg::CNT_W'(1);
		end else if (int'(win_q) > swm_pkg::MAX_WINDOW) begin
			w_eff = swm_pkg::CNT_W'(swm_pkg::MAX_WINDOW);
		end else begin
			w_eff = swm_pkg::CNT_W'(win_q);
		end
		full_now = (fill_q >= w_eff);
		if (!full_now) begin
			slot_now = fill_q[swm_pkg::IDX_W-1:0];
		end else if (swm_pkg::CNT_W'(ptr_q) < w_eff) begin
			slot_now = ptr_q;
		end else begin
			slot_now = '0;
		end
		slot_inc  = swm_pkg::CNT_W'(slot_now) + swm_pkg::CNT_W'(1);
		accept    = in_valid && (state_q == swm_pkg::ST_IDLE);
		last_step = (state_q == swm_pkg::ST_STEP) && (i_q == len_q);
		out_free  = !out_valid_q || !out_stall;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = swm_pkg::ST_PRIME;
				end
			end
			swm_pkg::ST_PRIME: begin
				state_d = swm_pkg::ST_STEP;
			end
			swm_pkg::ST_STEP: begin
				if (i_q == len_q) begin
					state_d = res_q ? swm_pkg::ST_DONE : swm_pkg::ST_IDLE;
				end
			end
			swm_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = swm_pkg::ST_IDLE;
				end
			end
			default: state_d = swm_pkg::ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd            = '0;
		cmd.full       = full_q;
		cmd.ring_raddr = slot_now;
		cmd.ring_waddr = slot_q;
		cmd.sort_waddr = i_q;
		unique case (state_q)
			swm_pkg::ST_IDLE: begin
				cmd.capture    = accept;
				cmd.sort_raddr = '0;
			end
			swm_pkg::ST_PRIME: begin
				cmd.prime      = 1'b1;
				cmd.ring_we    = 1'b1;
				cmd.sort_raddr = swm_pkg::IDX_W'(1);
			end
			swm_pkg::ST_STEP: begin
				cmd.step       = 1'b1;
				cmd.sort_we    = 1'b1;
				cmd.sort_raddr = i_q + swm_pkg::IDX_W'(2);
				cmd.last       = last_step;
				cmd.med_hit    = (i_q == med_idx_q);
			end
			swm_pkg::ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swm_pkg::ST_IDLE;
			win_q       <= swm_pkg::WIN_RESET;
			fill_q      <= '0;
			ptr_q       <= '0;
			i_q         <= '0;
			full_q      <= 1'b0;
			res_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (window_size_we) begin
				win_q  <= window_size;
				fill_q <= '0;
				ptr_q  <= '0;
			end else if (accept) begin
				if (!full_now) begin
					fill_q <= fill_q + swm_pkg::CNT_W'(1);
				end else if (slot_inc >= w_eff) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= slot_inc[swm_pkg::IDX_W-1:0];
				end
			end
			if (accept) begin
				full_q <= full_now;
				res_q  <= full_now || ((fill_q + swm_pkg::CNT_W'(1)) == w_eff);
			end
			if (state_q == swm_pkg::ST_PRIME) begin
				i_q <= '0;
			end else if (state_q == swm_pkg::ST_STEP) begin
				i_q <= i_q + swm_pkg::IDX_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q    <= slot_now;
			len_q     <= full_now ? swm_pkg::IDX_W'(w_eff - swm_pkg::CNT_W'(1))
			                      : fill_q[swm_pkg::IDX_W-1:0];
			med_idx_q <= swm_pkg::IDX_W'((w_eff - swm_pkg::CNT_W'(1)) >> 1);
		end
	end

	assign in_stall  = (state_q != swm_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	`SWM_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= w_eff)
	`SWM_ASSERT_NXT(a_accept_primes, accept, state_q == swm_pkg::ST_PRIME)
	`SWM_ASSERT_IMP(a_step_bound, state_q == swm_pkg::ST_STEP, i_q <= len_q)
	`SWM_ASSERT_NXT(a_done_holds, (state_q == swm_pkg::ST_DONE) && out_valid_q && out_stall,
		state_q == swm_pkg::ST_DONE)

endmodule
